// ===== rtl/fqs_pkg.sv =====
// Package: sizes, codes, state encoding and helpers of the searchable FIFO queue.
`timescale 1ns / 1ps

package fqs_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic        [PTR_W-1:0]       ptr_t;
  typedef logic        [CNT_W-1:0]       cnt_t;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPRD,
    S_SCAN,
    S_HOLD
  } state_t;

  // Circular pointer advance; works for any depth, not only powers of two.
  function automatic ptr_t next_ptr(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/fqs_if.sv =====
// Interfaces: request and response channels of the searchable FIFO queue.
`timescale 1ns / 1ps

interface fqs_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  op;
  logic signed [31:0] operand_value;

  modport source (output valid, output op, output operand_value, input ready);
  modport sink   (input valid, input op, input operand_value, output ready);
endinterface

interface fqs_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] popped_value;
  logic               found;
  logic        [3:0]  found_position;
  logic        [4:0]  entry_count;
  logic signed [31:0] min_value;
  logic signed [31:0] max_value;

  modport source (output valid, output status, output popped_value, output found,
                  output found_position, output entry_count, output min_value,
                  output max_value, input ready);
  modport sink   (input valid, input status, input popped_value, input found,
                  input found_position, input entry_count, input min_value,
                  input max_value, output ready);
endinterface

// ===== rtl/fifo_queue_search_min_max.sv =====
// Top level: bounded FIFO queue with push, pop, key search and min/max report.
//
//   channel | direction | payload
//   --------+-----------+-------------------------------------------------------
//   req     | in        | op, operand_value
//   rsp     | out       | status, popped_value, found, found_position,
//           |           | entry_count, min_value, max_value
//
// One item is handled at a time. An item passes through an execute state, a pop
// read state for a pop that removes an entry, and a walk that reads every entry
// left after the operation, one entry per cycle, through the single read port of
// the entry memory, and then a hold state that loads the result; the next item is
// taken back in the idle state. When the queue is empty after the operation there
// is nothing to read and the walk closes at once.
// Reset clears the pointers, the count and all handshake state; the memory
// contents are not cleared, since no entry is read before it has been written.
// A result waits in the output register while the next item is already taken
// and worked on; only the final load waits for the output register to drain.
`timescale 1ns / 1ps

module fifo_queue_search_min_max
  import fqs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  fqs_req_if.sink   req,
  fqs_rsp_if.source rsp
);

  // Entry memory, one write and one registered read port.
  value_t mem [DEPTH];
  value_t rd_data;
  ptr_t   rd_addr;
  logic   mem_we;

  state_t state, state_next;

  // Item context.
  logic [1:0] cur_op;
  value_t     key;

  // Queue pointers and fill count.
  ptr_t head;
  ptr_t tail;
  cnt_t count;

  // Walk over the stored entries.
  ptr_t scan_ptr;
  cnt_t issue_cnt;
  cnt_t proc_cnt;
  logic rd_vld;
  logic issue_more;

  // Result being built.
  status_t status;
  value_t  popped;
  logic    found;
  ptr_t    found_pos;
  value_t  min_val;
  value_t  max_val;

  // Output register.
  logic              out_valid;
  logic              load_out;
  status_t           out_status;
  logic signed [31:0] out_popped;
  logic              out_found;
  logic [3:0]        out_pos;
  logic [4:0]        out_count;
  logic signed [31:0] out_min;
  logic signed [31:0] out_max;

  logic full;
  logic empty;

  assign full       = (count == cnt_t'(DEPTH));
  assign empty      = (count == '0);
  assign issue_more = (issue_cnt < count);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((cur_op == OP_POP) && !empty) begin
          state_next = S_POPRD;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_POPRD: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!rd_vld && (proc_cnt == count)) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    req.ready = 1'b0;
    mem_we    = 1'b0;
    load_out  = 1'b0;
    rd_addr   = head;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
      end
      S_EXEC: begin
        mem_we = (cur_op == OP_PUSH) && !full;
      end
      S_SCAN: begin
        rd_addr = scan_ptr;
      end
      S_HOLD: begin
        load_out = !out_valid || rsp.ready;
      end
      default: begin
        rd_addr = head;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= key;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pointers, count and walk control.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rd_vld    <= 1'b0;
      issue_cnt <= '0;
      proc_cnt  <= '0;
    end else begin
      case (state)
        S_EXEC: begin
          issue_cnt <= '0;
          proc_cnt  <= '0;
          rd_vld    <= 1'b0;
          if ((cur_op == OP_PUSH) && !full) begin
            tail  <= next_ptr(tail);
            count <= count + cnt_t'(1);
          end else if ((cur_op == OP_POP) && !empty) begin
            head  <= next_ptr(head);
            count <= count - cnt_t'(1);
          end
        end
        S_SCAN: begin
          rd_vld <= issue_more;
          if (issue_more) begin
            issue_cnt <= issue_cnt + cnt_t'(1);
          end
          if (rd_vld) begin
            proc_cnt <= proc_cnt + cnt_t'(1);
          end
        end
        default: begin
          rd_vld <= 1'b0;
        end
      endcase
    end
  end

  // Item capture and result building.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          cur_op <= req.op;
          key    <= value_t'(req.operand_value);
        end
      end
      S_EXEC: begin
        popped    <= '0;
        found     <= 1'b0;
        found_pos <= '0;
        min_val   <= '0;
        max_val   <= '0;
        // The walk starts at the head as it stands after this operation.
        if ((cur_op == OP_POP) && !empty) begin
          scan_ptr <= next_ptr(head);
        end else begin
          scan_ptr <= head;
        end
        if ((cur_op == OP_PUSH) && full) begin
          status <= STAT_FULL;
        end else if (((cur_op == OP_POP) || (cur_op == OP_SEARCH)) && empty) begin
          status <= STAT_EMPTY;
        end else if (cur_op == OP_SEARCH) begin
          status <= STAT_NOT_FOUND;
        end else begin
          status <= STAT_OK;
        end
      end
      S_POPRD: begin
        popped <= rd_data;
      end
      S_SCAN: begin
        if (issue_more) begin
          scan_ptr <= next_ptr(scan_ptr);
        end
        if (rd_vld) begin
          if ((proc_cnt == '0) || (rd_data < min_val)) begin
            min_val <= rd_data;
          end
          if ((proc_cnt == '0) || (rd_data > max_val)) begin
            max_val <= rd_data;
          end
          // Only the first match from the head counts.
          if ((cur_op == OP_SEARCH) && !found && (rd_data == key)) begin
            found     <= 1'b1;
            found_pos <= ptr_t'(proc_cnt);
            status    <= STAT_OK;
          end
        end
      end
      default: begin
        status <= status;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= status;
      out_popped <= 32'(popped);
      out_found  <= found;
      out_pos    <= 4'(found_pos);
      out_count  <= 5'(count);
      out_min    <= 32'(min_val);
      out_max    <= 32'(max_val);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.popped_value   = out_popped;
  assign rsp.found          = out_found;
  assign rsp.found_position = out_pos;
  assign rsp.entry_count    = out_count;
  assign rsp.min_value      = out_min;
  assign rsp.max_value      = out_max;

endmodule

// ===== rtl/fqs_checker.sv =====
// Checker: port-level properties of the searchable FIFO queue, bound to the top level.
`timescale 1ns / 1ps

module fqs_checker
  import fqs_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [1:0]        rsp_status,
  input logic              rsp_found,
  input logic [4:0]        rsp_entry_count,
  input logic signed [31:0] rsp_min_value,
  input logic signed [31:0] rsp_max_value
);

  // A stalled result keeps its fields.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_entry_count) && $stable(rsp_min_value) && $stable(rsp_max_value))
    else $error("response changed while stalled");

  // An empty queue reports zero for both extremes; otherwise min never exceeds max.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_entry_count == 5'd0) |-> (rsp_min_value == 32'sd0) &&
      (rsp_max_value == 32'sd0))
    else $error("empty queue with nonzero min or max");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_min_value <= rsp_max_value) &&
      (rsp_entry_count <= 5'(DEPTH)))
    else $error("min above max or count beyond depth");

  // A hit always carries the ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> (rsp_status == STAT_OK))
    else $error("found flag without ok status");

  // A dropped push only happens when the queue is full.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STAT_FULL) |-> (rsp_entry_count == 5'(DEPTH)))
    else $error("full status with a queue that is not full");

endmodule

bind fifo_queue_search_min_max fqs_checker u_fqs_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_found       (rsp.found),
  .rsp_entry_count (rsp.entry_count),
  .rsp_min_value   (rsp.min_value),
  .rsp_max_value   (rsp.max_value)
);
